FILE: design/svi_pkg.sv
// ----------------------------------------------------------------------------
// svi_pkg
// Shared types and constants for the subsequence value iteration block.
// ----------------------------------------------------------------------------
package svi_pkg;

	// default string length; the vector holds 2^(2L-1) words
	localparam int STRING_LENGTH_DEF = 5;
	localparam logic [31:0] FPO_RESET = 32'd25000000;

	// command codes
	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_WRITE = 2'd1,
		OP_SWEEP = 2'd2,
		OP_READ  = 2'd3
	} op_e;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_WRITE,
		ST_READ,
		ST_READ_WAIT,
		ST_LOWER,
		ST_UPPER,
		ST_WR_A,
		ST_WR_B,
		ST_COMPARE,
		ST_FINISH
	} state_e;

	typedef struct packed {
		op_e         operation;
		logic [8:0]  index;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic [31:0] min_change;
		logic        decrease_seen;
	} rsp_t;

endpackage

FILE: design/svi_ram.sv
// ----------------------------------------------------------------------------
// svi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module svi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: design/subsequence_value_iteration.sv
// ----------------------------------------------------------------------------
// subsequence_value_iteration
// Fixed-point value vector with value-iteration sweeps over two banks.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on cmd (valid/stall); one response leaves on rsp for
//   every command. cmd_stall is high while a command is in progress, so one
//   command runs at a time. A finished response sits in an output register,
//   and the next command is taken while it waits.
//   The vector RAM has a single read port: a lower entry gathers four
//   words, an upper entry eight, and the change scan reads the new and
//   old word of each entry. fixed_point_one is written through
//   cfg_we/cfg_wdata; the user must write it only while idle, as the
//   block does not enforce this. After reset bank a is cleared, one word
//   a cycle, over all of its words; cmd is stalled meanwhile. A response
//   stalled by rsp_stall holds; a finished command waits in its last
//   state until the register frees up.
// ----------------------------------------------------------------------------
module subsequence_value_iteration
	import svi_pkg::*;
#(
	parameter int STRING_LENGTH = STRING_LENGTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_t        cmd,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	localparam int IW   = 2 * STRING_LENGTH - 1;
	localparam int SW   = IW + 1;
	localparam int VEC  = 1 << IW;
	localparam int HALF = 1 << (IW - 1);
	localparam int QTR  = 1 << (IW - 2);
	localparam int AW   = IW + 1;

	localparam logic [IW-1:0] LAST_IDX = IW'(VEC - 1);
	localparam logic [IW-1:0] LAST_QTR = IW'(QTR - 1);
	localparam logic [SW-1:0] ODD_MASK  = {STRING_LENGTH{2'b10}};
	localparam logic [SW-1:0] EVEN_MASK = {STRING_LENGTH{2'b01}};

	state_e state_q, state_d;

	logic [IW-1:0] cnt_q;
	logic [3:0]    k_q;
	logic          bank_q, init_q, upper_q;
	logic [31:0]   fpo_q;
	op_e           op_q;
	logic [IW-1:0] idx_q;
	logic [31:0]   val_q;
	logic [31:0]   acc_q, half_q, pair_q, res_a_q, res_b_q, nval_q;
	logic [31:0]   rd_q, min_q;
	logic          dec_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic          cmd_xfer, rsp_free;
	logic [IW+8:0] idx_ext;
	logic [2:0]    slot;
	logic [31:0]   pair_sum, diff;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [31:0]   ram_wdata, ram_rdata;

	// upper-half gather addresses
	logic [SW-1:0] s_full, comp, partner, a_bits, tb, atb0, ta0b, ta3, b3, c0, c1, atb0_2;
	logic [IW-1:0] up_addr, wr_addr_a, wr_addr_b;

	assign cmd_xfer  = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign idx_ext   = {{IW{1'b0}}, cmd.index};
	assign slot      = 3'(k_q - 4'd1);

	// index arithmetic of the upper sweep half
	always_comb begin
		s_full  = SW'(HALF) + SW'(cnt_q);
		comp    = ~s_full;
		partner = comp - SW'(HALF);
		a_bits  = s_full & ODD_MASK;
		tb      = s_full & EVEN_MASK & SW'(HALF - 1);
		atb0    = a_bits | (tb << 2);
		ta0b    = (a_bits << 2) | tb;
		ta3     = comp & ODD_MASK & SW'(VEC - 1);
		b3      = comp & EVEN_MASK;
		c0      = ~((ta3 << 2) | b3);
		c1      = c0 & ~SW'(2);
		atb0_2  = ta3 | (b3 << 2);
		case (k_q[2:0])
			3'd0:    up_addr = atb0[IW-1:0];
			3'd1:    up_addr = atb0[IW-1:0] | IW'(1);
			3'd2:    up_addr = c0[IW-1:0];
			3'd3:    up_addr = c1[IW-1:0];
			3'd4:    up_addr = ta0b[IW-1:0];
			3'd5:    up_addr = ta0b[IW-1:0] | IW'(2);
			3'd6:    up_addr = atb0_2[IW-1:0];
			default: up_addr = atb0_2[IW-1:0] | IW'(1);
		endcase
		if (upper_q) begin
			wr_addr_a = s_full[IW-1:0];
			wr_addr_b = partner[IW-1:0];
		end else begin
			wr_addr_a = cnt_q;
			wr_addr_b = IW'(HALF - 1) - cnt_q;
		end
	end

	// halved pair sum and change of the entry under scan
	assign pair_sum = half_q + (ram_rdata >> 1);
	assign diff     = nval_q - ram_rdata;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_xfer) begin
					case (cmd.operation)
						OP_CLEAR: state_d = ST_CLEAR;
						OP_WRITE: state_d = ST_WRITE;
						OP_SWEEP: state_d = ST_LOWER;
						default:  state_d = ST_READ;
					endcase
				end
			end
			ST_CLEAR: begin
				if (cnt_q == LAST_IDX) state_d = init_q ? ST_IDLE : ST_FINISH;
			end
			ST_WRITE:     state_d = ST_FINISH;
			ST_READ:      state_d = ST_READ_WAIT;
			ST_READ_WAIT: state_d = ST_FINISH;
			ST_LOWER: begin
				if (k_q == 4'd4) state_d = ST_WR_A;
			end
			ST_UPPER: begin
				if (k_q == 4'd8) state_d = ST_WR_A;
			end
			ST_WR_A: state_d = ST_WR_B;
			ST_WR_B: begin
				if (cnt_q == LAST_QTR) state_d = upper_q ? ST_COMPARE : ST_UPPER;
				else state_d = upper_q ? ST_UPPER : ST_LOWER;
			end
			ST_COMPARE: begin
				if (k_q == 4'd2 && cnt_q == LAST_IDX) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (rsp_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {bank_q, cnt_q};
		ram_wdata = '0;
		ram_raddr = {bank_q, cnt_q};
		case (state_q)
			ST_CLEAR: ram_we = 1'b1;
			ST_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = {bank_q, idx_q};
				ram_wdata = val_q;
			end
			ST_READ:  ram_raddr = {bank_q, idx_q};
			ST_LOWER: ram_raddr = {bank_q, cnt_q[IW-3:0], k_q[1:0]};
			ST_UPPER: ram_raddr = {bank_q, up_addr};
			ST_WR_A: begin
				ram_we    = 1'b1;
				ram_waddr = {~bank_q, wr_addr_a};
				ram_wdata = res_a_q;
			end
			ST_WR_B: begin
				ram_we    = 1'b1;
				ram_waddr = {~bank_q, wr_addr_b};
				ram_wdata = upper_q ? res_b_q : res_a_q;
			end
			ST_COMPARE: ram_raddr = {(k_q == 4'd0) ? ~bank_q : bank_q, cnt_q};
			default: ram_we = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			k_q         <= '0;
			bank_q      <= 1'b0;
			init_q      <= 1'b1;
			upper_q     <= 1'b0;
			fpo_q       <= FPO_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) fpo_q <= cfg_wdata;
			// response register: load on finish, drop after a transfer
			if (state_q == ST_FINISH && rsp_free) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q   <= '0;
					k_q     <= '0;
					upper_q <= 1'b0;
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + IW'(1);
					if (cnt_q == LAST_IDX) init_q <= 1'b0;
				end
				ST_LOWER, ST_UPPER: k_q <= k_q + 4'd1;
				ST_WR_B: begin
					k_q <= '0;
					if (cnt_q == LAST_QTR) begin
						cnt_q   <= '0;
						upper_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + IW'(1);
					end
				end
				ST_COMPARE: begin
					if (k_q == 4'd2) begin
						k_q   <= '0;
						cnt_q <= cnt_q + IW'(1);
						if (cnt_q == LAST_IDX) bank_q <= ~bank_q;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				default: k_q <= k_q;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_xfer) begin
					op_q  <= cmd.operation;
					idx_q <= idx_ext[IW-1:0];
					val_q <= cmd.value;
					rd_q  <= '0;
					dec_q <= 1'b0;
					min_q <= (cmd.operation == OP_SWEEP) ? '1 : '0;
				end
			end
			ST_READ_WAIT: rd_q <= ram_rdata;
			ST_LOWER: begin
				// four quarter-weighted words on top of fixed_point_one
				if (k_q != 4'd0)
					acc_q <= ((k_q == 4'd1) ? fpo_q : acc_q) + (ram_rdata >> 2);
				if (k_q == 4'd4)
					res_a_q <= ((k_q == 4'd1) ? fpo_q : acc_q) + (ram_rdata >> 2);
			end
			ST_UPPER: begin
				// pairs: first, second -> entry s; third, fourth -> partner
				if (k_q != 4'd0) begin
					if (!slot[0]) begin
						half_q <= ram_rdata >> 1;
					end else begin
						case (slot[2:1])
							2'd1:    res_a_q <= (pair_q > pair_sum) ? pair_q : pair_sum;
							2'd3:    res_b_q <= (pair_q > pair_sum) ? pair_q : pair_sum;
							default: pair_q  <= pair_sum;
						endcase
					end
				end
			end
			ST_COMPARE: begin
				if (k_q == 4'd1) nval_q <= ram_rdata;
				if (k_q == 4'd2) begin
					if (diff < min_q) min_q <= diff;
					if (nval_q < ram_rdata) dec_q <= 1'b1;
				end
			end
			ST_FINISH: begin
				if (rsp_free) begin
					rsp_q.read_value    <= (op_q == OP_READ) ? rd_q : '0;
					rsp_q.min_change    <= min_q;
					rsp_q.decrease_seen <= dec_q;
				end
			end
			default: nval_q <= nval_q;
		endcase
	end

	// both banks in one RAM, bank select as the top address bit
	svi_ram #(
		.WIDTH (32),
		.DEPTH (2 * VEC)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

FILE: design/svi_checker.sv
// ----------------------------------------------------------------------------
// svi_checker
// Port-level checks for the subsequence value iteration block.
// ----------------------------------------------------------------------------
module svi_checker
	import svi_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// response only leaves through a transfer
	a_rsp_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rsp_valid) |-> $past(!rsp_stall))
		else $error("response dropped without transfer");

	// one command at a time
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command taken while busy");

	// read data and sweep results never share a response
	a_rsp_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.read_value != 32'd0 |-> rsp.min_change == 32'd0 && !rsp.decrease_seen)
		else $error("mixed response fields");

endmodule

bind subsequence_value_iteration svi_checker u_svi_checker (.*);

FILE: tb/subsequence_value_iteration_test.sv
// ----------------------------------------------------------------------------
// subsequence_value_iteration_test
// Self-checking bench for the value iteration block. Commands are driven with
// random gaps and responses taken under random stalls. A behavioral model of
// both vector banks predicts every response, and a monitor compares each
// response field by field against the oldest prediction. Directed tests cover
// reset contents, index and value extremes, clear and sweep wrap-around; a
// random phase mixes writes, reads, sweeps and clears over several settings
// of fixed_point_one.
// ----------------------------------------------------------------------------
module subsequence_value_iteration_test;
	import svi_pkg::*;

	localparam int VEC = 512;
	localparam logic [63:0] ODD_MASK = 64'hAAAAAAAAAAAAAAAA;
	localparam logic [63:0] EVEN_MASK = 64'h5555555555555555;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	logic cfg_we;
	logic [31:0] cfg_wdata;

	subsequence_value_iteration uut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// vector model: two banks, one current
	logic [31:0] bank [2][VEC];
	int cur_bank;
	logic [31:0] model_fpo;

	rsp_t pending_rsp[$];
	int mismatches;
	int checked;
	int n_sweep, n_write, n_read, n_clear, n_cfg;
	bit quiet;

	function automatic logic [31:0] pair_sum(int b, logic [63:0] i, logic [63:0] j);
		return (bank[b][i[8:0]] >> 1) + (bank[b][j[8:0]] >> 1);
	endfunction

	// one sweep from current bank into the other, then swap
	function automatic void sweep_banks(output logic [31:0] min_c, output logic dec);
		int o;
		int n;
		logic [31:0] acc, p1, p2, p3, p4, d;
		logic [63:0] s, comp, partner, a, tb, atb0, ta0b, ta3, b3, c0, c1, atb0_2;
		o = cur_bank;
		n = 1 - cur_bank;
		for (int k = 0; k < 128; k++) begin
			acc = model_fpo;
			for (int m = 0; m < 4; m++)
				acc = acc + (bank[o][(k << 2) | m] >> 2);
			bank[n][k] = acc;
			bank[n][255 - k] = acc;
		end
		for (int k = 256; k < 384; k++) begin
			s = k;
			comp = 64'd1023 - s;
			partner = comp - 64'd256;
			a = s & ODD_MASK;
			tb = (s & EVEN_MASK) & 64'd255;
			atb0 = a | (tb << 2);
			ta0b = (a << 2) | tb;
			ta3 = (comp & ODD_MASK) & 64'd511;
			b3 = comp & EVEN_MASK;
			c0 = 64'd1023 - ((ta3 << 2) | b3);
			c1 = c0 & ~64'd2;
			atb0_2 = ta3 | (b3 << 2);
			p1 = pair_sum(o, atb0, atb0 | 64'd1);
			p2 = pair_sum(o, ta0b, ta0b | 64'd2);
			p3 = pair_sum(o, c0, c1);
			p4 = pair_sum(o, atb0_2, atb0_2 | 64'd1);
			bank[n][s[8:0]] = (p1 > p3) ? p1 : p3;
			bank[n][partner[8:0]] = (p2 > p4) ? p2 : p4;
		end
		min_c = 32'hFFFFFFFF;
		dec = 1'b0;
		for (int k = 0; k < VEC; k++) begin
			d = bank[n][k] - bank[o][k];
			if (d < min_c)
				min_c = d;
			if (bank[n][k] < bank[o][k])
				dec = 1'b1;
		end
		cur_bank = n;
	endfunction

	// advance the model by one command and return its response
	function automatic rsp_t model_command(cmd_t c);
		rsp_t r;
		r = '0;
		case (c.operation)
			OP_CLEAR: begin
				for (int k = 0; k < VEC; k++)
					bank[cur_bank][k] = '0;
				n_clear++;
			end
			OP_WRITE: begin
				bank[cur_bank][c.index] = c.value;
				n_write++;
			end
			OP_SWEEP: begin
				sweep_banks(r.min_change, r.decrease_seen);
				n_sweep++;
			end
			default: begin
				r.read_value = bank[cur_bank][c.index];
				n_read++;
			end
		endcase
		return r;
	endfunction

	// gap length: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (quiet || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	// response stall generator
	int stall_left;
	always @(negedge clk) begin
		if (!arst_n) begin
			stall_left = 0;
			rsp_stall = 1'b0;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			rsp_stall = 1'b1;
		end else begin
			stall_left = pick_gap();
			rsp_stall = (stall_left > 0);
			if (stall_left > 0)
				stall_left = stall_left - 1;
		end
	end

	// response monitor
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			checked++;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response %h", rsp);
			end else begin
				e = pending_rsp.pop_front();
				if (rsp.read_value !== e.read_value || rsp.min_change !== e.min_change
						|| rsp.decrease_seen !== e.decrease_seen) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: read %h/%h min %h/%h dec %b/%b (exp/act)",
							e.read_value, rsp.read_value, e.min_change, rsp.min_change,
							e.decrease_seen, rsp.decrease_seen);
				end
			end
		end
	end

	// drive one command; entered and left at a falling edge
	task automatic send_cmd(op_e op, logic [8:0] idx, logic [31:0] val);
		int gap;
		gap = pick_gap();
		repeat (gap) @(negedge clk);
		cmd.operation = op;
		cmd.index = idx;
		cmd.value = val;
		cmd_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (!cmd_stall)
				break;
			@(negedge clk);
		end
		pending_rsp.push_back(model_command(cmd));
		@(negedge clk);
		cmd_valid = 1'b0;
	endtask

	// wait for every outstanding response, then let the block idle
	task automatic drain();
		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_fpo(logic [31:0] v);
		drain();
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		model_fpo = v;
		n_cfg++;
	endtask

	task automatic test_reset_contents();
		send_cmd(OP_READ, 9'd0, $urandom);
		send_cmd(OP_READ, 9'd511, $urandom);
	endtask

	task automatic test_write_read_extremes();
		send_cmd(OP_WRITE, 9'd0, 32'hFFFFFFFF);
		send_cmd(OP_WRITE, 9'd511, 32'h0);
		send_cmd(OP_WRITE, 9'd256, 32'h80000001);
		send_cmd(OP_READ, 9'd0, 32'h0);
		send_cmd(OP_READ, 9'd511, 32'hFFFFFFFF);
		send_cmd(OP_READ, 9'd256, 32'h0);
	endtask

	task automatic test_clear();
		send_cmd(OP_CLEAR, 9'd0, 32'h0);
		send_cmd(OP_READ, 9'd0, 32'h0);
	endtask

	// large entries make sums wrap and entries decrease
	task automatic test_sweep_wrap();
		write_fpo(32'hFFFFFFFF);
		send_cmd(OP_SWEEP, 9'd0, 32'h0);
		send_cmd(OP_READ, 9'd3, 32'h0);
		for (int k = 0; k < 4; k++)
			send_cmd(OP_WRITE, 9'(k * 97 + 5), 32'hFFFFFFFF);
		send_cmd(OP_SWEEP, 9'd0, 32'h0);
		write_fpo(32'h0);
		send_cmd(OP_SWEEP, 9'd0, 32'h0);
		send_cmd(OP_READ, 9'd300, 32'h0);
		write_fpo(FPO_RESET);
		send_cmd(OP_SWEEP, 9'd0, 32'h0);
	endtask

	// sender holds off until the block has answered everything
	task automatic test_pause_drain();
		send_cmd(OP_WRITE, 9'd170, $urandom);
		drain();
		send_cmd(OP_READ, 9'd170, 32'h0);
	endtask

	task automatic test_random_mix();
		int r;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 4)
				0: write_fpo($urandom);
				1: write_fpo(32'hFFFFFFFF);
				2: write_fpo(32'h0);
				default: write_fpo(FPO_RESET);
			endcase
			quiet = (ph == 2);
			for (int k = 0; k < 44; k++) begin
				r = $urandom_range(99);
				if (r < 55)
					send_cmd(OP_WRITE, 9'($urandom), (r < 20) ? $urandom_range(1000) : $urandom);
				else if (r < 82)
					send_cmd(OP_READ, 9'($urandom), $urandom);
				else if (r < 97)
					send_cmd(OP_SWEEP, 9'($urandom), $urandom);
				else
					send_cmd(OP_CLEAR, 9'($urandom), $urandom);
			end
			quiet = 1'b0;
		end
	endtask

	// give up after a generous bound
	initial begin
		#80000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		quiet = 1'b0;
		n_sweep = 0;
		n_write = 0;
		n_read = 0;
		n_clear = 0;
		n_cfg = 0;
		cur_bank = 0;
		model_fpo = FPO_RESET;
		for (int k = 0; k < VEC; k++) begin
			bank[0][k] = '0;
			bank[1][k] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_contents();
		test_write_read_extremes();
		test_clear();
		test_sweep_wrap();
		test_pause_drain();
		test_random_mix();

		drain();
		repeat (20) @(negedge clk);
		$display("covered %0d responses: %0d sweeps, %0d writes, %0d reads, %0d clears",
			checked, n_sweep, n_write, n_read, n_clear);
		$display("fixed_point_one written %0d times; %0d mismatches", n_cfg, mismatches);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: sim.f
design/svi_pkg.sv
design/svi_ram.sv
design/subsequence_value_iteration.sv
design/svi_checker.sv
tb/subsequence_value_iteration_test.sv
